>>> src/srm_pkg.sv
// srm_pkg: shared types and constants for the SPI register access master.
// No dependencies; used by srm_front, srm_back and the top level.

package srm_pkg;

	localparam int MAX_READ_BYTES  = 4;
	localparam int MAX_WRITE_BYTES = 3;
	localparam int CNT_W           = 3;
	localparam int BITS_W          = 6;
	localparam int Q_DEPTH         = 4;
	localparam int Q_PTR_W         = $clog2(Q_DEPTH);
	localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

	localparam logic [5:0] ADDR_MASK  = 6'h3F;
	localparam logic       WRITE_FLAG = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_BAD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_IGNORED = 2'd1,
		ST_BUSY    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_TICK   = 2'd0,
		K_START  = 2'd1,
		K_IGNORE = 2'd2
	} kind_t;

	// classified item handed from front to back
	typedef struct packed {
		kind_t             kind;
		logic              is_read;
		logic [1:0]        chip;
		logic [7:0]        header;
		logic [23:0]       wdata;
		logic [CNT_W-1:0]  count;
		logic              miso;
	} item_t;

	typedef struct packed {
		logic        mosi;
		logic [1:0]  chip_select;
		logic        sck_pulse;
		logic        done_res;
		logic [31:0] read_data;
		status_t     status;
	} result_t;

endpackage

>>> src/srm_front.sv
// srm_front: accepts input transfers, classifies them and queues them.
// Depends on srm_pkg.

module srm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [1:0]          chip,
	input  logic [7:0]          reg_addr,
	input  logic [2:0]          byte_count,
	input  logic [23:0]         write_data,
	input  logic                miso_bit,
	output logic                q_valid,
	output srm_pkg::item_t      q_item,
	input  logic                q_pop
);

	srm_pkg::item_t                      cls;
	srm_pkg::item_t                      mem_q [srm_pkg::Q_DEPTH];
	logic [srm_pkg::Q_PTR_W-1:0]         wr_ptr_q;
	logic [srm_pkg::Q_PTR_W-1:0]         rd_ptr_q;
	logic [srm_pkg::Q_CNT_W-1:0]         cnt_q;
	logic                                full;
	logic                                push;
	logic                                pop;

	// classify: saturate counts, build header
	always_comb begin
		cls         = '0;
		cls.chip    = chip;
		cls.wdata   = write_data;
		cls.miso    = miso_bit;
		cls.count   = byte_count;
		cls.header  = {1'b0, 1'b0, reg_addr[5:0] & srm_pkg::ADDR_MASK};
		unique case (srm_pkg::op_t'(op))
			srm_pkg::OP_TICK: begin
				cls.kind = srm_pkg::K_TICK;
			end
			srm_pkg::OP_READ: begin
				cls.kind    = srm_pkg::K_START;
				cls.is_read = 1'b1;
				if (byte_count > srm_pkg::CNT_W'(srm_pkg::MAX_READ_BYTES))
					cls.count = srm_pkg::CNT_W'(srm_pkg::MAX_READ_BYTES);
			end
			srm_pkg::OP_WRITE: begin
				cls.kind      = srm_pkg::K_START;
				cls.header[7] = srm_pkg::WRITE_FLAG;
				if (byte_count > srm_pkg::CNT_W'(srm_pkg::MAX_WRITE_BYTES))
					cls.count = srm_pkg::CNT_W'(srm_pkg::MAX_WRITE_BYTES);
			end
			default: begin
				cls.kind = srm_pkg::K_IGNORE;
			end
		endcase
	end

	assign full     = (cnt_q == srm_pkg::Q_CNT_W'(srm_pkg::Q_DEPTH));
	assign in_stall = full;
	assign push     = in_valid && !full;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= srm_pkg::Q_CNT_W'(srm_pkg::Q_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != srm_pkg::Q_CNT_W'(srm_pkg::Q_DEPTH)) |->
		((wr_ptr_q - rd_ptr_q) == cnt_q[srm_pkg::Q_PTR_W-1:0]))
		else $error("queue pointers disagree with count");

endmodule

>>> src/srm_back.sv
// srm_back: runs the SPI transaction state, one queued item per cycle unless stalled,
// and holds the result in an output register. Depends on srm_pkg.

module srm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  srm_pkg::item_t      q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output srm_pkg::result_t    res
);

	logic                              busy_q;
	logic                              is_read_q;
	logic [1:0]                        active_chip_q;
	logic [31:0]                       out_shift_q;
	logic [srm_pkg::BITS_W-1:0]        bits_left_q;
	logic [srm_pkg::BITS_W-1:0]        data_bits_q;
	logic [31:0]                       in_shift_q;
	logic                              mosi_hold_q;
	logic                              out_valid_q;
	srm_pkg::result_t                  res_q;

	logic                              busy_d;
	logic                              is_read_d;
	logic [1:0]                        active_chip_d;
	logic [31:0]                       out_shift_d;
	logic [srm_pkg::BITS_W-1:0]        bits_left_d;
	logic [srm_pkg::BITS_W-1:0]        data_bits_d;
	logic [31:0]                       in_shift_d;
	logic                              mosi_hold_d;
	srm_pkg::result_t                  res_d;
	logic                              ready;
	logic                              data_phase;
	logic [1:0]                        cur_cs;

	assign ready = !out_valid_q || !out_stall;
	assign q_pop = q_valid && ready;
	assign out_valid = out_valid_q;
	assign res = res_q;
	assign cur_cs = busy_q ? active_chip_q : 2'd0;
	assign data_phase = (bits_left_q <= data_bits_q);

	always_comb begin
		busy_d        = busy_q;
		is_read_d     = is_read_q;
		active_chip_d = active_chip_q;
		out_shift_d   = out_shift_q;
		bits_left_d   = bits_left_q;
		data_bits_d   = data_bits_q;
		in_shift_d    = in_shift_q;
		mosi_hold_d   = mosi_hold_q;
		res_d             = '0;
		res_d.mosi        = mosi_hold_q;
		res_d.chip_select = cur_cs;
		res_d.status      = srm_pkg::ST_OK;
		unique case (q_item.kind)
			srm_pkg::K_START: begin
				if (busy_q) begin
					res_d.status = srm_pkg::ST_BUSY;
				end else begin
					busy_d            = 1'b1;
					is_read_d         = q_item.is_read;
					active_chip_d     = q_item.chip;
					out_shift_d       = {q_item.header, q_item.wdata};
					data_bits_d       = {q_item.count, 3'b000};
					bits_left_d       = {q_item.count, 3'b000} + srm_pkg::BITS_W'(8);
					in_shift_d        = '0;
					res_d.chip_select = q_item.chip;
				end
			end
			srm_pkg::K_TICK: begin
				if (!busy_q) begin
					res_d.mosi        = 1'b0;
					res_d.chip_select = 2'd0;
					res_d.status      = srm_pkg::ST_IGNORED;
				end else begin
					res_d.sck_pulse = 1'b1;
					if (is_read_q && data_phase) begin
						in_shift_d = {in_shift_q[30:0], q_item.miso};
					end else begin
						res_d.mosi  = out_shift_q[31];
						mosi_hold_d = out_shift_q[31];
						out_shift_d = {out_shift_q[30:0], 1'b0};
					end
					bits_left_d = bits_left_q - 1'b1;
					if (bits_left_q == srm_pkg::BITS_W'(1)) begin
						res_d.done_res = 1'b1;
						if (is_read_q)
							res_d.read_data = in_shift_d;
						busy_d        = 1'b0;
						active_chip_d = 2'd0;
					end
				end
			end
			default: begin
				res_d.status = srm_pkg::ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			is_read_q     <= 1'b0;
			active_chip_q <= 2'd0;
			out_shift_q   <= '0;
			bits_left_q   <= '0;
			data_bits_q   <= '0;
			in_shift_q    <= '0;
			mosi_hold_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q        <= busy_d;
				is_read_q     <= is_read_d;
				active_chip_q <= active_chip_d;
				out_shift_q   <= out_shift_d;
				bits_left_q   <= bits_left_d;
				data_bits_q   <= data_bits_d;
				in_shift_q    <= in_shift_d;
				mosi_hold_q   <= mosi_hold_d;
			end
			if (ready)
				out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			res_q <= res_d;
	end

	a_done_has_clock: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> res_q.sck_pulse && res_q.status == srm_pkg::ST_OK)
		else $error("done without a clock period");

	a_idle_no_chip: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> active_chip_q == 2'd0)
		else $error("chip held while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> bits_left_q != '0 && bits_left_q <= data_bits_q + srm_pkg::BITS_W'(8))
		else $error("bit counter out of range");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && res_d.done_res |=> !busy_q)
		else $error("still busy after final period");

endmodule

>>> src/spi_register_access_master.sv
// spi_register_access_master: top level of the SPI register access master.
// Depends on srm_pkg, srm_front and srm_back.
// A result passes through the front-end queue and the back end's output register before it is offered.
// Throughput: one item per cycle while the receiver does not stall; set by
// the back end, which retires one queued item per cycle into its output register.
// Reset: asynchronous, active low; clears queue, transaction state and
// output valid at once, no clearing pass.

module spi_register_access_master (
	input  logic         clk,
	input  logic         arst_n,
	// input channel
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   op,
	input  logic [1:0]   chip,
	input  logic [7:0]   reg_addr,
	input  logic [2:0]   byte_count,
	input  logic [23:0]  write_data,
	input  logic         miso_bit,
	// result channel
	output logic         out_valid,
	input  logic         out_stall,
	output logic         mosi,
	output logic [1:0]   chip_select,
	output logic         sck_pulse,
	output logic         done_res,
	output logic [31:0]  read_data,
	output logic [1:0]   status
);

	// Front end: decodes op, saturates the byte count (three for writes,
	// four for reads), forms the header byte and queues the classified item
	// in a four-entry queue. It stalls only when that queue is full.
	logic               q_valid;
	logic               q_pop;
	srm_pkg::item_t     q_item;
	srm_pkg::result_t   res;

	srm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.chip       (chip),
		.reg_addr   (reg_addr),
		.byte_count (byte_count),
		.write_data (write_data),
		.miso_bit   (miso_bit),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// Back end: holds the transaction state (busy, shifters, bit counters)
	// and produces exactly one result per item. It pops the queue whenever
	// its output register is empty or being taken, so a waiting result does
	// not block the next item from being worked on until the register is
	// actually full and stalled.
	srm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// result fields onto their own ports
	assign mosi        = res.mosi;
	assign chip_select = res.chip_select;
	assign sck_pulse   = res.sck_pulse;
	assign done_res    = res.done_res;
	assign read_data   = res.read_data;
	assign status      = res.status;

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for the SPI register access master.
// Depends on srm_pkg and spi_register_access_master; a built-in predictor
// tracks the transaction state and checks each result transfer in order.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_stall;
	logic [1:0]   op;
	logic [1:0]   chip;
	logic [7:0]   reg_addr;
	logic [2:0]   byte_count;
	logic [23:0]  write_data;
	logic         miso_bit;
	logic         out_valid;
	logic         out_stall;
	logic         mosi;
	logic [1:0]   chip_select;
	logic         sck_pulse;
	logic         done_res;
	logic [31:0]  read_data;
	logic [1:0]   status;

	spi_register_access_master dut (.*);

	// Predictor state: mirrors the master's view of the current transaction
	bit           spi_busy;
	bit           spi_is_read;
	logic [1:0]   spi_chip;
	logic [31:0]  spi_out_sr;     // header in 31..24, write bytes below
	logic [5:0]   spi_bits_left;  // SCK periods still to run
	logic [5:0]   spi_data_bits;  // periods belonging to the data phase
	logic [31:0]  spi_in_sr;      // MISO accumulator
	logic         spi_mosi_hold;  // last MOSI level driven

	srm_pkg::result_t pending_results[$];
	srm_pkg::result_t oldest;
	int           mismatches;
	int           items_done;     // transfers that were not simply ignored
	int           tx_seq;
	bit           tx_calm;        // sender idles nowhere in this stretch
	bit           rx_calm;        // receiver stalls nowhere in this stretch
	bit           no_idle;        // tail of the run: neither side idles

	// Clock: 2 ns period
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

	// Works out the result one input transfer causes and advances the state.
	function automatic srm_pkg::result_t spi_master_next(srm_pkg::op_t o, logic [1:0] c,
			logic [7:0] a, logic [2:0] n, logic [23:0] w, logic m);
		srm_pkg::result_t r;
		logic [2:0] nbytes;
		logic [1:0] cur_cs;
		logic [7:0] header;
		logic       bit_out;
		r = '0;
		cur_cs = spi_busy ? spi_chip : 2'd0;
		case (o)
			srm_pkg::OP_BAD: begin
				// undefined op: state untouched, current levels reported
				r.mosi        = spi_mosi_hold;
				r.chip_select = cur_cs;
				r.status      = srm_pkg::ST_IGNORED;
			end
			srm_pkg::OP_READ, srm_pkg::OP_WRITE: begin
				if (spi_busy) begin
					r.mosi        = spi_mosi_hold;
					r.chip_select = cur_cs;
					r.status      = srm_pkg::ST_BUSY;
				end else begin
					nbytes = n;
					if (o == srm_pkg::OP_WRITE && n > 3'(srm_pkg::MAX_WRITE_BYTES))
						nbytes = 3'(srm_pkg::MAX_WRITE_BYTES);
					if (o == srm_pkg::OP_READ && n > 3'(srm_pkg::MAX_READ_BYTES))
						nbytes = 3'(srm_pkg::MAX_READ_BYTES);
					header        = {o == srm_pkg::OP_WRITE, 1'b0,
						a[5:0] & srm_pkg::ADDR_MASK};
					spi_is_read   = (o == srm_pkg::OP_READ);
					spi_busy      = 1'b1;
					spi_chip      = c;
					spi_out_sr    = {header, w};
					spi_data_bits = {nbytes, 3'b000};
					spi_bits_left = 6'd8 + {nbytes, 3'b000};
					spi_in_sr     = '0;
					r.mosi        = spi_mosi_hold;
					r.chip_select = c;
					r.status      = srm_pkg::ST_OK;
				end
			end
			default: begin
				if (!spi_busy) begin
					r.status = srm_pkg::ST_IGNORED;
				end else begin
					r.chip_select = spi_chip;
					r.sck_pulse   = 1'b1;
					r.status      = srm_pkg::ST_OK;
					if (spi_is_read && spi_bits_left <= spi_data_bits) begin
						// read data period: MOSI parked, MISO shifted in
						bit_out   = spi_mosi_hold;
						spi_in_sr = {spi_in_sr[30:0], m};
					end else begin
						bit_out       = spi_out_sr[31];
						spi_out_sr    = spi_out_sr << 1;
						spi_mosi_hold = bit_out;
					end
					r.mosi        = bit_out;
					spi_bits_left = spi_bits_left - 6'd1;
					if (spi_bits_left == 6'd0) begin
						r.done_res  = 1'b1;
						r.read_data = spi_is_read ? spi_in_sr : 32'd0;
						spi_busy    = 1'b0;
						spi_chip    = 2'd0;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// One input transfer. Called at a falling edge, returns at a falling edge.
	task automatic send_item(srm_pkg::op_t o, logic [1:0] c, logic [7:0] a, logic [2:0] n,
			logic [23:0] w, logic m);
		srm_pkg::result_t r;
		if (!no_idle && !tx_calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		chip       <= c;
		reg_addr   <= a;
		byte_count <= n;
		write_data <= w;
		miso_bit   <= m;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		r = spi_master_next(o, c, a, n, w, m);
		pending_results.push_back(r);
		if (r.status != srm_pkg::ST_IGNORED)
			items_done++;
		@(negedge clk);
		tx_seq++;
		if (tx_seq % 40 == 0)
			tx_calm = ($urandom_range(0, 2) == 0);
	endtask

	// Result side: every accepted transfer must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected result, expected none, got status %0h",
					$time, status);
			end else begin
				oldest = pending_results.pop_front();
				check_field("mosi", 32'(oldest.mosi), 32'(mosi));
				check_field("chip_select", 32'(oldest.chip_select), 32'(chip_select));
				check_field("sck_pulse", 32'(oldest.sck_pulse), 32'(sck_pulse));
				check_field("done_res", 32'(oldest.done_res), 32'(done_res));
				check_field("read_data", oldest.read_data, read_data);
				check_field("status", 32'(oldest.status), 32'(status));
			end
		end
	end

	// Receiver back-pressure: random bursts of stalled cycles, with calm stretches
	initial begin
		int cyc;
		cyc       = 0;
		out_stall = 1'b0;
		rx_calm   = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 128 == 0)
				rx_calm = ($urandom_range(0, 2) == 0);
			if (!no_idle && !rx_calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [23:0] pick_wdata();
		case ($urandom_range(0, 5))
			0:       return 24'h000000;
			1:       return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	// Ticks and the undefined op with nothing in flight
	task automatic test_idle_items();
		send_item(srm_pkg::OP_TICK, 2'd3, 8'hFF, 3'd7, 24'hFFFFFF, 1'b1);
		send_item(srm_pkg::OP_BAD, 2'd3, 8'hFF, 3'd7, 24'hFFFFFF, 1'b1);
		send_item(srm_pkg::OP_TICK, 2'd0, 8'h00, 3'd0, 24'h000000, 1'b0);
	endtask

	// Header-only write to chip 3 with top address bits set; a refused start
	// and an undefined op land in the middle of it
	task automatic test_write_header_only();
		int k;
		send_item(srm_pkg::OP_WRITE, 2'd3, 8'hFF, 3'd0, 24'hFFFFFF, 1'b0);
		k = 0;
		while (spi_busy) begin
			if (k == 3)
				send_item(srm_pkg::OP_READ, 2'd1, 8'h15, 3'd4, 24'h0, 1'b1);
			else if (k == 4)
				send_item(srm_pkg::OP_BAD, 2'd2, 8'h2A, 3'd1, 24'h0, 1'b0);
			else
				send_item(srm_pkg::OP_TICK, 2'd0, 8'h00, 3'd0, 24'h0, 1'b1);
			k++;
		end
	endtask

	// Header-only read with no chip selected: reports zero data
	task automatic test_read_header_only();
		send_item(srm_pkg::OP_READ, 2'd0, 8'h40, 3'd0, 24'h000000, 1'b0);
		while (spi_busy)
			send_item(srm_pkg::OP_TICK, 2'd0, 8'h00, 3'd0, 24'h0, 1'b1);
	endtask

	// One well-formed transaction with random content, sprinkled with noise
	task automatic run_transaction();
		srm_pkg::op_t kind;
		int  r;
		if ($urandom_range(0, 7) == 0)
			send_item(srm_pkg::op_t'($urandom_range(0, 3)), 2'($urandom), 8'($urandom),
				3'($urandom), 24'($urandom), 1'($urandom));
		if (!spi_busy) begin
			kind = $urandom_range(0, 1) ? srm_pkg::OP_WRITE : srm_pkg::OP_READ;
			send_item(kind, 2'($urandom), 8'($urandom), 3'($urandom_range(0, 7)),
				pick_wdata(), 1'($urandom));
		end
		while (spi_busy) begin
			r = $urandom_range(0, 24);
			if (r == 0)
				send_item(srm_pkg::op_t'($urandom_range(1, 2)), 2'($urandom),
					8'($urandom), 3'($urandom), 24'($urandom), 1'($urandom));
			else if (r == 1)
				send_item(srm_pkg::OP_BAD, 2'($urandom), 8'($urandom), 3'($urandom),
					24'($urandom), 1'($urandom));
			else
				send_item(srm_pkg::OP_TICK, 2'($urandom), 8'($urandom), 3'($urandom),
					24'($urandom), 1'($urandom));
		end
	endtask

	task automatic test_random_transactions(int target);
		while (items_done < target)
			run_transaction();
	endtask

	// Tail: neither side idles, so transfers go back to back
	task automatic test_back_to_back(int target);
		no_idle = 1'b1;
		while (items_done < target)
			run_transaction();
	endtask

	initial begin
		int waited;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = srm_pkg::OP_TICK;
		chip          = '0;
		reg_addr      = '0;
		byte_count    = '0;
		write_data    = '0;
		miso_bit      = 1'b0;
		spi_busy      = 1'b0;
		spi_is_read   = 1'b0;
		spi_chip      = '0;
		spi_out_sr    = '0;
		spi_bits_left = '0;
		spi_data_bits = '0;
		spi_in_sr     = '0;
		spi_mosi_hold = 1'b0;
		mismatches    = 0;
		items_done    = 0;
		tx_seq        = 0;
		tx_calm       = 1'b0;
		no_idle       = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_items();
		test_write_header_only();
		test_read_header_only();
		test_random_transactions(780);
		test_back_to_back(860);

		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			if (pending_results.size() != 0)
				$display("%0t ns: %0d results never arrived, expected 0 outstanding, got %0d",
					$time, pending_results.size(), pending_results.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
src/srm_pkg.sv
src/srm_front.sv
src/srm_back.sv
src/spi_register_access_master.sv
sim/tb_top.sv
